FILE: hdl/bfpix_pkg.sv
// Shared types, register codes, reset values and helper functions for the
// bitfield pixel to BGRA converter. No dependencies.
package bfpix_pkg;

  localparam int WORD_W    = 32;
  localparam int CHAN_W    = 8;
  localparam int POS_W     = 6;
  localparam int INDEX_W   = 3;
  localparam int NUM_CHAN  = 4;
  localparam int PIPE_DEPTH = 7;

  localparam logic [INDEX_W-1:0] REG_MASK_RED   = 3'd0;
  localparam logic [INDEX_W-1:0] REG_MASK_GREEN = 3'd1;
  localparam logic [INDEX_W-1:0] REG_MASK_BLUE  = 3'd2;
  localparam logic [INDEX_W-1:0] REG_MASK_ALPHA = 3'd3;
  localparam logic [INDEX_W-1:0] REG_PIXEL_MODE = 3'd4;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;
  localparam logic [1:0] CH_ALPHA = 2'd3;

  localparam logic [WORD_W-1:0] RESET_MASK_RED   = 32'h00FF_0000;
  localparam logic [WORD_W-1:0] RESET_MASK_GREEN = 32'h0000_FF00;
  localparam logic [WORD_W-1:0] RESET_MASK_BLUE  = 32'h0000_00FF;
  localparam logic [WORD_W-1:0] RESET_MASK_ALPHA = 32'hFF00_0000;

  localparam logic MODE_PACKED = 1'b0;
  localparam logic MODE_MASKED = 1'b1;

  localparam logic [CHAN_W-1:0] OPAQUE     = 8'hFF;
  localparam logic [CHAN_W-1:0] CHAN_EMPTY = 8'h00;

  typedef struct packed {
    logic [WORD_W-1:0] mask;
    logic [POS_W-1:0]  shift;
    logic [POS_W-1:0]  width;
    logic [WORD_W-1:0] maxv;
    logic [WORD_W-1:0] half;
    logic [WORD_W-1:0] recip;
    logic              empty;
    logic              full_byte;
  } chan_cfg_t;

  // Position of the lowest set bit; 32 for a zero word.
  function automatic logic [POS_W-1:0] trail_zeros(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] low;
    logic [POS_W-1:0]  pos;
    low = x & (~x + 32'd1);
    pos = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (low[i]) begin
        pos = pos | POS_W'(i);
      end
    end
    if (x == '0) begin
      pos = 6'd32;
    end
    return pos;
  endfunction

  // floor(2^32 / (2^width - 1)), saturated to all ones for a one-bit field.
  function automatic logic [WORD_W-1:0] recip_of_width(input logic [POS_W-1:0] width);
    logic [WORD_W-1:0] r;
    int                pos;
    r = '0;
    if (width != '0) begin
      for (int k = 1; k <= WORD_W; k++) begin
        pos = WORD_W - k * int'(width);
        if (pos >= 0) begin
          r[pos[4:0]] = 1'b1;
        end
      end
    end
    return r;
  endfunction

endpackage

FILE: hdl/bitfield_pixel_to_bgra.sv
// Bitfield pixel to BGRA converter, top level. Uses bfpix_pkg, bfpix_cfg,
// bfpix_chan.
// A transaction taken at a clock edge moves through the vld shift register and
// shows on done and the registered result ports for one cycle. Throughput:
// one transaction per cycle while busy is low. busy is high only during reset
// and the cycle after; reset restores the default masks and masked mode.
module bitfield_pixel_to_bgra (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [bfpix_pkg::WORD_W-1:0]     pixel_word,
  input  logic                             cfg_we,
  input  logic [bfpix_pkg::INDEX_W-1:0]    cfg_index,
  input  logic [bfpix_pkg::WORD_W-1:0]     cfg_data,
  output logic                             done,
  output logic [bfpix_pkg::CHAN_W-1:0]     blue,
  output logic [bfpix_pkg::CHAN_W-1:0]     green,
  output logic [bfpix_pkg::CHAN_W-1:0]     red,
  output logic [bfpix_pkg::CHAN_W-1:0]     alpha,
  output logic                             has_color,
  output logic                             has_alpha
);

  localparam int PASS_DEPTH = bfpix_pkg::PIPE_DEPTH - 1;

  typedef struct packed {
    logic        mode;
    logic [23:0] bytes;
  } pass_t;

  bfpix_pkg::chan_cfg_t          chan_cfg [bfpix_pkg::NUM_CHAN];
  logic                          pixel_mode;
  logic [bfpix_pkg::WORD_W-1:0]  word_s1;
  logic [bfpix_pkg::CHAN_W-1:0]  chan_res [bfpix_pkg::NUM_CHAN];
  logic [bfpix_pkg::PIPE_DEPTH-1:0] vld;
  pass_t                         pass [PASS_DEPTH];
  logic                          accept;
  logic [bfpix_pkg::CHAN_W-1:0]  blue_next;
  logic [bfpix_pkg::CHAN_W-1:0]  green_next;
  logic [bfpix_pkg::CHAN_W-1:0]  red_next;
  logic [bfpix_pkg::CHAN_W-1:0]  alpha_next;
  pass_t                         pass_out;

  assign accept   = start & ~busy;
  assign pass_out = pass[PASS_DEPTH-1];

  bfpix_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .chan_cfg   (chan_cfg),
    .pixel_mode (pixel_mode)
  );

  for (genvar c = 0; c < bfpix_pkg::NUM_CHAN; c++) begin : g_chan
    bfpix_chan u_chan (
      .clk        (clk),
      .word       (word_s1),
      .cfg        (chan_cfg[c]),
      .empty_fill ((c == int'(bfpix_pkg::CH_ALPHA)) ? bfpix_pkg::OPAQUE
                                                    : bfpix_pkg::CHAN_EMPTY),
      .result     (chan_res[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      vld  <= '0;
      done <= 1'b0;
    end else begin
      busy <= 1'b0;
      vld  <= {vld[bfpix_pkg::PIPE_DEPTH-2:0], accept};
      done <= vld[bfpix_pkg::PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    word_s1 <= pixel_word;
    pass[0] <= '{mode: pixel_mode, bytes: word_s1[23:0]};
    for (int i = 1; i < PASS_DEPTH; i++) begin
      pass[i] <= pass[i-1];
    end
  end

  always_comb begin
    if (pass_out.mode == bfpix_pkg::MODE_PACKED) begin
      blue_next  = pass_out.bytes[7:0];
      green_next = pass_out.bytes[15:8];
      red_next   = pass_out.bytes[23:16];
      alpha_next = bfpix_pkg::OPAQUE;
    end else begin
      blue_next  = chan_res[bfpix_pkg::CH_BLUE];
      green_next = chan_res[bfpix_pkg::CH_GREEN];
      red_next   = chan_res[bfpix_pkg::CH_RED];
      alpha_next = chan_res[bfpix_pkg::CH_ALPHA];
    end
  end

  always_ff @(posedge clk) begin
    blue      <= blue_next;
    green     <= green_next;
    red       <= red_next;
    alpha     <= alpha_next;
    has_color <= |{blue_next, green_next, red_next};
    has_alpha <= |alpha_next;
  end

endmodule

FILE: hdl/bfpix_cfg.sv
// Configuration registers and per-channel mask decode (shift, width,
// divisor and reciprocal). Depends on bfpix_pkg.
module bfpix_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bfpix_pkg::INDEX_W-1:0]       cfg_index,
  input  logic [bfpix_pkg::WORD_W-1:0]        cfg_data,
  output bfpix_pkg::chan_cfg_t                chan_cfg [bfpix_pkg::NUM_CHAN],
  output logic                                pixel_mode
);

  logic [bfpix_pkg::WORD_W-1:0] mask_red;
  logic [bfpix_pkg::WORD_W-1:0] mask_green;
  logic [bfpix_pkg::WORD_W-1:0] mask_blue;
  logic [bfpix_pkg::WORD_W-1:0] mask_alpha;
  logic [bfpix_pkg::WORD_W-1:0] mask_vec [bfpix_pkg::NUM_CHAN];

  logic [bfpix_pkg::POS_W-1:0]  shift    [bfpix_pkg::NUM_CHAN];
  logic [bfpix_pkg::POS_W-1:0]  run_top  [bfpix_pkg::NUM_CHAN];
  logic [bfpix_pkg::POS_W-1:0]  width    [bfpix_pkg::NUM_CHAN];
  logic [bfpix_pkg::WORD_W-1:0] maxv     [bfpix_pkg::NUM_CHAN];
  logic [bfpix_pkg::WORD_W-1:0] half     [bfpix_pkg::NUM_CHAN];
  logic [bfpix_pkg::WORD_W-1:0] recip    [bfpix_pkg::NUM_CHAN];
  logic                         empty    [bfpix_pkg::NUM_CHAN];
  logic                         full_byte[bfpix_pkg::NUM_CHAN];

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_red   <= bfpix_pkg::RESET_MASK_RED;
      mask_green <= bfpix_pkg::RESET_MASK_GREEN;
      mask_blue  <= bfpix_pkg::RESET_MASK_BLUE;
      mask_alpha <= bfpix_pkg::RESET_MASK_ALPHA;
      pixel_mode <= bfpix_pkg::MODE_MASKED;
    end else if (cfg_we) begin
      case (cfg_index)
        bfpix_pkg::REG_MASK_RED:   mask_red   <= cfg_data;
        bfpix_pkg::REG_MASK_GREEN: mask_green <= cfg_data;
        bfpix_pkg::REG_MASK_BLUE:  mask_blue  <= cfg_data;
        bfpix_pkg::REG_MASK_ALPHA: mask_alpha <= cfg_data;
        bfpix_pkg::REG_PIXEL_MODE: pixel_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mask_vec[bfpix_pkg::CH_RED]   = mask_red;
    mask_vec[bfpix_pkg::CH_GREEN] = mask_green;
    mask_vec[bfpix_pkg::CH_BLUE]  = mask_blue;
    mask_vec[bfpix_pkg::CH_ALPHA] = mask_alpha;
  end

  // First decode level: field start and the bit just above the lowest run.
  always_ff @(posedge clk) begin
    for (int c = 0; c < bfpix_pkg::NUM_CHAN; c++) begin
      shift[c]   <= bfpix_pkg::trail_zeros(mask_vec[c]);
      run_top[c] <= bfpix_pkg::trail_zeros(mask_vec[c] +
                                           (mask_vec[c] & (~mask_vec[c] + 32'd1)));
    end
  end

  // Second decode level: run width, the divisor it implies, its half and reciprocal, and the empty and full-byte flags.
  always_ff @(posedge clk) begin
    logic [bfpix_pkg::POS_W-1:0]  wdiff;
    logic [bfpix_pkg::WORD_W:0]   ones;
    for (int c = 0; c < bfpix_pkg::NUM_CHAN; c++) begin
      wdiff        = run_top[c] - shift[c];
      ones         = (33'd1 << wdiff) - 33'd1;
      width[c]     <= wdiff;
      maxv[c]      <= ones[bfpix_pkg::WORD_W-1:0];
      half[c]      <= {1'b0, ones[bfpix_pkg::WORD_W-1:1]};
      recip[c]     <= bfpix_pkg::recip_of_width(wdiff);
      empty[c]     <= (shift[c] == 6'd32);
      full_byte[c] <= (wdiff == 6'd8);
    end
  end

  always_comb begin
    for (int c = 0; c < bfpix_pkg::NUM_CHAN; c++) begin
      chan_cfg[c].mask      = mask_vec[c];
      chan_cfg[c].shift     = shift[c];
      chan_cfg[c].width     = width[c];
      chan_cfg[c].maxv      = maxv[c];
      chan_cfg[c].half      = half[c];
      chan_cfg[c].recip     = recip[c];
      chan_cfg[c].empty     = empty[c];
      chan_cfg[c].full_byte = full_byte[c];
    end
  end

endmodule

FILE: hdl/bfpix_chan.sv
// One channel datapath: mask, shift, rescale to 0..255 through a reciprocal multiply with a one-step remainder
// correction; an empty mask gives empty_fill and an 8-bit field passes unscaled. Depends on bfpix_pkg.
module bfpix_chan (
  input  logic                             clk,
  input  logic [bfpix_pkg::WORD_W-1:0]     word,
  input  bfpix_pkg::chan_cfg_t             cfg,
  input  logic [bfpix_pkg::CHAN_W-1:0]     empty_fill,
  output logic [bfpix_pkg::CHAN_W-1:0]     result
);

  logic [bfpix_pkg::WORD_W-1:0]   masked;
  logic [bfpix_pkg::WORD_W-1:0]   raw;
  logic [bfpix_pkg::WORD_W-1:0]   biased;
  logic [bfpix_pkg::WORD_W-1:0]   biased_d;
  logic [2*bfpix_pkg::WORD_W-1:0] prod;
  logic [bfpix_pkg::WORD_W+1:0]   rem;
  logic [bfpix_pkg::CHAN_W-1:0]   quot_lo;
  logic [bfpix_pkg::CHAN_W-1:0]   raw_lo4;
  logic [bfpix_pkg::CHAN_W-1:0]   raw_lo5;
  logic [bfpix_pkg::CHAN_W-1:0]   raw_lo6;
  logic [bfpix_pkg::WORD_W-1:0]   quot_est;

  assign quot_est = prod[2*bfpix_pkg::WORD_W-1:bfpix_pkg::WORD_W];

  always_ff @(posedge clk) begin
    masked   <= word & cfg.mask;
    raw      <= masked >> cfg.shift;
    biased   <= (raw << 8) - raw + cfg.half;
    raw_lo4  <= raw[bfpix_pkg::CHAN_W-1:0];
    prod     <= 64'(biased) * 64'(cfg.recip);
    biased_d <= biased;
    raw_lo5  <= raw_lo4;
    rem      <= 34'(biased_d) + 34'(quot_est) - (34'(quot_est) << cfg.width);
    quot_lo  <= quot_est[bfpix_pkg::CHAN_W-1:0];
    raw_lo6  <= raw_lo5;
    if (cfg.empty) begin
      result <= empty_fill;
    end else if (cfg.full_byte) begin
      result <= raw_lo6;
    end else begin
      result <= quot_lo + 8'(rem >= 34'(cfg.maxv));
    end
  end

endmodule

FILE: verif/bitfield_pixel_to_bgra_tb.sv
// Self-checking testbench for bitfield_pixel_to_bgra: directed reset-default, packed-mode, mask-corner and spare-index
// tests, then random masks and pixels under varied start gaps. Depends on bfpix_pkg and the RTL.
module bitfield_pixel_to_bgra_tb;
  import bfpix_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = PIPE_DEPTH + 4;
  localparam logic [INDEX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [INDEX_W-1:0] REG_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] alpha;
    logic              has_color;
    logic              has_alpha;
  } bgra_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [WORD_W-1:0]   pixel_word;
  logic                cfg_we;
  logic [INDEX_W-1:0]  cfg_index;
  logic [WORD_W-1:0]   cfg_data;
  logic                done;
  logic [CHAN_W-1:0]   blue;
  logic [CHAN_W-1:0]   green;
  logic [CHAN_W-1:0]   red;
  logic [CHAN_W-1:0]   alpha;
  logic                has_color;
  logic                has_alpha;

  logic [WORD_W-1:0]   mask_red;
  logic [WORD_W-1:0]   mask_green;
  logic [WORD_W-1:0]   mask_blue;
  logic [WORD_W-1:0]   mask_alpha;
  logic                pixel_mode;

  bgra_t               pending_pixels[$];
  int                  mismatches;

  bitfield_pixel_to_bgra i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .pixel_word (pixel_word),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .done       (done),
    .blue       (blue),
    .green      (green),
    .red        (red),
    .alpha      (alpha),
    .has_color  (has_color),
    .has_alpha  (has_alpha)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [CHAN_W-1:0] scale_channel(input logic [WORD_W-1:0] word,
                                                       input logic [WORD_W-1:0] mask);
    logic [WORD_W-1:0] rest;
    logic [WORD_W-1:0] raw;
    logic [WORD_W-1:0] top;
    logic [WORD_W-1:0] sum;
    int                shift;
    int                width;
    if (mask == '0) begin
      return CHAN_EMPTY;
    end
    rest = mask;
    shift = 0;
    width = 0;
    while (!rest[0]) begin
      rest = rest >> 1;
      shift++;
    end
    while (rest[0]) begin
      rest = rest >> 1;
      width++;
    end
    raw = (word & mask) >> shift;
    if (width == CHAN_W) begin
      return raw[CHAN_W-1:0];
    end
    top = (width >= WORD_W) ? '1 : ((32'd1 << width) - 32'd1);
    sum = raw * 32'd255 + (top >> 1);
    sum = sum / top;
    return sum[CHAN_W-1:0];
  endfunction

  function automatic bgra_t convert_pixel(input logic [WORD_W-1:0] word);
    bgra_t px;
    if (pixel_mode == MODE_PACKED) begin
      px.blue  = word[7:0];
      px.green = word[15:8];
      px.red   = word[23:16];
      px.alpha = OPAQUE;
    end else begin
      px.red   = scale_channel(word, mask_red);
      px.green = scale_channel(word, mask_green);
      px.blue  = scale_channel(word, mask_blue);
      px.alpha = (mask_alpha != '0) ? scale_channel(word, mask_alpha) : OPAQUE;
    end
    px.has_color = (px.red | px.green | px.blue) != '0;
    px.has_alpha = px.alpha != '0;
    return px;
  endfunction

  function automatic logic [WORD_W-1:0] random_mask();
    logic [63:0] run;
    int          width;
    int          shift;
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      7, 8: return $urandom;
      9: begin
        shift = $urandom_range(24);
        return 32'h0000_00FF << shift;
      end
      default: begin
        width = $urandom_range(1, 32);
        shift = $urandom_range(32 - width);
        run = ((64'd1 << width) - 64'd1) << shift;
        return run[WORD_W-1:0];
      end
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(15))
      0: return '0;
      1: return '1;
      2: return 32'd1 << $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [CHAN_W-1:0] want,
                             input logic [CHAN_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    bgra_t want;
    bgra_t got;
    if (!rst && done === 1'b1) begin
      got = '{blue, green, red, alpha, has_color, has_alpha};
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none got %h", $time, got);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("blue", want.blue, got.blue);
        check_field("green", want.green, got.green);
        check_field("red", want.red, got.red);
        check_field("alpha", want.alpha, got.alpha);
        check_field("has_color", CHAN_W'(want.has_color), CHAN_W'(got.has_color));
        check_field("has_alpha", CHAN_W'(want.has_alpha), CHAN_W'(got.has_alpha));
      end
    end
  end

  // hold start high until a transaction is taken
  task automatic send_pixel(input logic [WORD_W-1:0] word);
    start <= 1'b1;
    pixel_word <= word;
    do @(posedge clk); while (busy);
    pending_pixels.push_back(convert_pixel(word));
  endtask

  task automatic idle_cycle();
    start <= 1'b0;
    pixel_word <= $urandom;
    @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [INDEX_W-1:0] index, input logic [WORD_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (index)
      REG_MASK_RED:   mask_red = value;
      REG_MASK_GREEN: mask_green = value;
      REG_MASK_BLUE:  mask_blue = value;
      REG_MASK_ALPHA: mask_alpha = value;
      REG_PIXEL_MODE: pixel_mode = value[0];
      default: ;
    endcase
  endtask

  task automatic set_masks(input logic [WORD_W-1:0] r, input logic [WORD_W-1:0] g,
                           input logic [WORD_W-1:0] b, input logic [WORD_W-1:0] a,
                           input logic mode);
    write_reg(REG_MASK_RED, r);
    write_reg(REG_MASK_GREEN, g);
    write_reg(REG_MASK_BLUE, b);
    write_reg(REG_MASK_ALPHA, a);
    write_reg(REG_PIXEL_MODE, {31'd0, mode});
  endtask

  task automatic test_reset_defaults();
    send_pixel('0);
    send_pixel('1);
    send_pixel(32'h1234_5678);
    send_pixel(32'h80FF_0001);
    drain_results();
  endtask

  // mode data with upper bits set must keep only bit 0
  task automatic test_packed_mode();
    write_reg(REG_PIXEL_MODE, 32'hFFFF_FFFE);
    send_pixel('1);
    send_pixel(32'hFF00_0000);
    send_pixel(32'h00A5_5A01);
    drain_results();
    write_reg(REG_PIXEL_MODE, 32'h0000_0001);
  endtask

  task automatic test_mask_corners();
    set_masks('0, '0, '0, '0, MODE_MASKED);
    send_pixel('1);
    drain_results();
    set_masks('1, '1, '1, '1, MODE_MASKED);
    send_pixel('1);
    send_pixel(32'h8000_0001);
    drain_results();
    set_masks(32'h8000_0000, 32'h0000_0001, 32'h0001_0000, 32'h4000_0000, MODE_MASKED);
    send_pixel('1);
    send_pixel(32'h4001_0000);
    drain_results();
    set_masks(32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, '0, MODE_MASKED);
    send_pixel(32'h0000_FFFF);
    send_pixel(32'hFFFF_0841);
    drain_results();
    set_masks(32'hF0F0_F0F0, 32'h0F0F_0F0F, 32'h00FF_00FF, 32'hFF00_FF00, MODE_MASKED);
    send_pixel('1);
    send_pixel(32'h5A5A_A5A5);
    drain_results();
    set_masks(32'h3FF0_0000, 32'h000F_FC00, 32'h0000_03FF, 32'hC000_0000, MODE_MASKED);
    send_pixel('1);
    send_pixel(32'h4010_0401);
    drain_results();
  endtask

  // writes to unused indexes must leave the masks alone
  task automatic test_spare_index();
    for (int i = int'(REG_SPARE_FIRST); i <= int'(REG_SPARE_LAST); i++) begin
      write_reg(INDEX_W'(i), '0);
    end
    send_pixel(32'hC030_0C03);
    drain_results();
  endtask

  task automatic test_random_traffic();
    int idle_pct;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 3)
        0: idle_pct = 0;
        1: idle_pct = 74;
        default: idle_pct = 25;
      endcase
      set_masks(random_mask(), random_mask(), random_mask(), random_mask(),
                ($urandom_range(3) == 0) ? MODE_PACKED : MODE_MASKED);
      for (int n = 0; n < 250; n++) begin
        while ($urandom_range(99) < idle_pct) idle_cycle();
        if ($urandom_range(199) == 0) begin
          drain_results();
        end
        send_pixel(random_word());
      end
      drain_results();
    end
  endtask

  initial begin
    mismatches = 0;
    mask_red = RESET_MASK_RED;
    mask_green = RESET_MASK_GREEN;
    mask_blue = RESET_MASK_BLUE;
    mask_alpha = RESET_MASK_ALPHA;
    pixel_mode = MODE_MASKED;
    rst <= 1'b1;
    start <= 1'b0;
    pixel_word <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_MASK_RED;
    cfg_data <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_packed_mode();
    test_mask_corners();
    test_spare_index();
    test_random_traffic();
    drain_results();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/bfpix_pkg.sv
hdl/bfpix_cfg.sv
hdl/bfpix_chan.sv
hdl/bitfield_pixel_to_bgra.sv
verif/bitfield_pixel_to_bgra_tb.sv
